>>> design/rpv_pkg.sv
// Shared types, constants and helper functions of the rectangular/polar vector converter.
// Used by the channel interfaces, rpv_rotate, rpv_vector and rect_polar_vector_converter.
package rpv_pkg;

    localparam int MAX_STAGES = 24;
    localparam int CW         = 24;
    localparam int AW         = 16;
    localparam int XW         = 35;
    localparam int ZW         = 21;
    localparam int GUARD      = 8;
    localparam int LO_W       = 17;
    localparam int HI_W       = XW - LO_W;
    localparam int GAIN_W     = 24;
    localparam int PH_W       = HI_W + GAIN_W + 1;
    localparam int PL_W       = LO_W + GAIN_W;
    localparam int PROD_W     = XW + GAIN_W + 2;
    localparam int DS_W       = PROD_W - 32;
    localparam int WRAP_W     = 18;

    localparam logic [GAIN_W-1:0]     INV_GAIN    = 24'd10188014;
    localparam logic [PROD_W-1:0]     HALF_ULP    = PROD_W'(33'h080000000);
    localparam logic signed [ZW-1:0]  PI_Q16      = 21'sd205887;
    localparam logic signed [ZW-1:0]  HALF_PI_Q16 = 21'sd102944;
    localparam logic [CW-1:0]         TWO_PI_Q13  = 24'd51472;
    localparam logic [CW-1:0]         PI_Q13      = 24'd25736;
    localparam logic signed [AW-1:0]  ANG_PI      = 16'sd25736;
    localparam logic signed [CW-1:0]  COORD_MAX   = 24'sh7FFFFF;
    localparam logic signed [CW-1:0]  COORD_MIN   = 24'sh800000;
    localparam logic [CW-1:0]         MAG_MAX     = 24'd11863283;

    typedef enum logic [1:0] {
        KIND_RECT    = 2'd0,
        KIND_POLAR   = 2'd1,
        KIND_INVALID = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic signed [CW-1:0] first_value;
        logic signed [CW-1:0] second_value;
    } req_t;

    typedef struct packed {
        logic                 bad;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } rect_t;

    typedef struct packed {
        logic                 bad;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [CW-1:0]        mag;
        logic signed [AW-1:0] ang;
    } res_t;

    // atan(2^-i), Q.16 radians
    function automatic logic signed [ZW-1:0] atan_q16(input int unsigned i);
        logic signed [ZW-1:0] r;
        case (i)
            0:       r = 21'sd51472;
            1:       r = 21'sd30386;
            2:       r = 21'sd16055;
            3:       r = 21'sd8150;
            4:       r = 21'sd4091;
            5:       r = 21'sd2047;
            6:       r = 21'sd1024;
            7:       r = 21'sd512;
            8:       r = 21'sd256;
            9:       r = 21'sd128;
            10:      r = 21'sd64;
            11:      r = 21'sd32;
            12:      r = 21'sd16;
            13:      r = 21'sd8;
            14:      r = 21'sd4;
            15:      r = 21'sd2;
            16:      r = 21'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    // sum of split partial products, rounded half up, back to Q.16
    function automatic logic signed [DS_W-1:0] descale(input logic signed [PH_W-1:0] ph,
                                                      input logic [PL_W-1:0] pl);
        logic signed [PROD_W-1:0] sum;
        sum = (PROD_W'(ph) <<< LO_W) + $signed(PROD_W'(pl)) + $signed(HALF_ULP);
        return $signed(sum[PROD_W-1:32]);
    endfunction

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [DS_W-1:0] v);
        logic signed [CW-1:0] r;
        if (v > DS_W'(COORD_MAX))
            r = COORD_MAX;
        else if (v < DS_W'(COORD_MIN))
            r = COORD_MIN;
        else
            r = v[CW-1:0];
        return r;
    endfunction

endpackage

>>> design/rpv_ifs.sv
// Valid/ready channel interfaces for request and result transactions.
// Depends on rpv_pkg for field widths.
interface rpv_req_if import rpv_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic signed [CW-1:0] first_value;
    logic signed [CW-1:0] second_value;

    modport source (output valid, output kind, output first_value, output second_value,
                    input ready);
    modport sink (input valid, input kind, input first_value, input second_value,
                  output ready);
endinterface

interface rpv_res_if import rpv_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] x_out;
    logic signed [CW-1:0] y_out;
    logic [CW-1:0]        magnitude;
    logic signed [AW-1:0] angle;
    logic                 invalid_form;

    modport source (output valid, output x_out, output y_out, output magnitude,
                    output angle, output invalid_form, input ready);
    modport sink (input valid, input x_out, input y_out, input magnitude,
                  input angle, input invalid_form, output ready);
endinterface

>>> design/rpv_rotate.sv
// Front pipeline: angle reduction, rotation-mode CORDIC and gain correction.
// Produces the rectangular form of every rectangular or polar request and flags invalid ones. Depends on rpv_pkg.
module rpv_rotate import rpv_pkg::*; #(
    parameter int STAGES = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  req_t  in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output rect_t out_data
);

    localparam int DEPTH = STAGES + 5;

    typedef struct packed {
        kind_t                kind;
        logic signed [CW-1:0] v1;
        logic signed [CW-1:0] v2;
        logic                 neg;
        logic [CW-1:0]        rem;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [PH_W-1:0] phx;
        logic signed [PH_W-1:0] phy;
        logic [PL_W-1:0]      plx;
        logic [PL_W-1:0]      ply;
        rect_t                res;
    } rot_t;

    rot_t             pipe_reg  [DEPTH];
    rot_t             pipe_next [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic [DEPTH:0]   rdy;

    assign rdy[DEPTH] = out_ready;
    assign in_ready   = rdy[0];
    assign out_valid  = vld_reg[DEPTH-1];
    assign out_data   = pipe_reg[DEPTH-1].res;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_stage
        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        if (k == 0)
        begin : g_src0
            assign vld_next[k] = in_valid;
        end
        else
        begin : g_srcn
            assign vld_next[k] = vld_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (rdy[k])
                vld_reg[k] <= vld_next[k];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
                pipe_reg[k] <= pipe_next[k];
        end

        if (k == 0)
        begin : g_reduce_hi
            always_comb
            begin
                rot_t n;
                logic [CW-1:0] rem;
                n = '0;
                if (in_data.kind == KIND_RECT)
                    n.kind = KIND_RECT;
                else if (in_data.kind == KIND_POLAR)
                    n.kind = KIND_POLAR;
                else
                    n.kind = KIND_INVALID;
                n.v1  = in_data.first_value;
                n.v2  = in_data.second_value;
                n.neg = in_data.second_value[CW-1];
                rem   = n.neg ? CW'(-in_data.second_value) : CW'(in_data.second_value);
                for (int j = 7; j >= 4; j--)
                begin
                    if (rem >= (TWO_PI_Q13 << j))
                        rem = rem - (TWO_PI_Q13 << j);
                end
                n.rem = rem;
                pipe_next[k] = n;
            end
        end
        else if (k == 1)
        begin : g_reduce_lo
            always_comb
            begin
                rot_t n;
                logic [CW-1:0] rem;
                n   = pipe_reg[k-1];
                rem = n.rem;
                for (int j = 3; j >= 0; j--)
                begin
                    if (rem >= (TWO_PI_Q13 << j))
                        rem = rem - (TWO_PI_Q13 << j);
                end
                n.rem = rem;
                pipe_next[k] = n;
            end
        end
        else if (k == 2)
        begin : g_prerot
            always_comb
            begin
                rot_t n;
                logic signed [WRAP_W-1:0] rs;
                n  = pipe_reg[k-1];
                rs = $signed(WRAP_W'(n.rem));
                if (n.rem > PI_Q13)
                    rs = rs - $signed(WRAP_W'(TWO_PI_Q13));
                if (n.neg)
                    rs = -rs;
                n.z = ZW'(rs) <<< 3;
                n.x = XW'(n.v1) <<< GUARD;
                n.y = '0;
                if (n.z > HALF_PI_Q16)
                begin
                    n.x = -n.x;
                    n.z = n.z - PI_Q16;
                end
                else if (n.z < -HALF_PI_Q16)
                begin
                    n.x = -n.x;
                    n.z = n.z + PI_Q16;
                end
                pipe_next[k] = n;
            end
        end
        else if (k < STAGES + 3)
        begin : g_cordic
            localparam int unsigned I = k - 3;
            always_comb
            begin
                rot_t n;
                logic signed [XW-1:0] xs;
                logic signed [XW-1:0] ys;
                n  = pipe_reg[k-1];
                xs = n.x >>> I;
                ys = n.y >>> I;
                if (n.z >= 0)
                begin
                    n.x = n.x - ys;
                    n.y = n.y + xs;
                    n.z = n.z - atan_q16(I);
                end
                else
                begin
                    n.x = n.x + ys;
                    n.y = n.y - xs;
                    n.z = n.z + atan_q16(I);
                end
                pipe_next[k] = n;
            end
        end
        else if (k == STAGES + 3)
        begin : g_mult
            always_comb
            begin
                rot_t n;
                n     = pipe_reg[k-1];
                n.phx = $signed(n.x[XW-1:LO_W]) * $signed({1'b0, INV_GAIN});
                n.phy = $signed(n.y[XW-1:LO_W]) * $signed({1'b0, INV_GAIN});
                n.plx = n.x[LO_W-1:0] * INV_GAIN;
                n.ply = n.y[LO_W-1:0] * INV_GAIN;
                pipe_next[k] = n;
            end
        end
        else
        begin : g_final
            always_comb
            begin
                rot_t n;
                n = pipe_reg[k-1];
                unique case (n.kind)
                    KIND_RECT:
                    begin
                        n.res.bad = 1'b0;
                        n.res.x   = n.v1;
                        n.res.y   = n.v2;
                    end
                    KIND_POLAR:
                    begin
                        n.res.bad = 1'b0;
                        n.res.x   = sat_coord(descale(n.phx, n.plx));
                        n.res.y   = sat_coord(descale(n.phy, n.ply));
                    end
                    default:
                    begin
                        n.res.bad = 1'b1;
                        n.res.x   = '0;
                        n.res.y   = '0;
                    end
                endcase
                pipe_next[k] = n;
            end
        end
    end

endmodule

>>> design/rpv_vector.sv
// Back pipeline: vectoring-mode CORDIC giving length and direction of (x, y).
// Takes rect_t from rpv_rotate and yields res_t. Depends on rpv_pkg.
module rpv_vector import rpv_pkg::*; #(
    parameter int STAGES = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  rect_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_data
);

    localparam int DEPTH = STAGES + 3;

    typedef struct packed {
        rect_t                rv;
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [PH_W-1:0] phx;
        logic [PL_W-1:0]      plx;
        res_t                 res;
    } vec_t;

    vec_t             pipe_reg  [DEPTH];
    vec_t             pipe_next [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic [DEPTH:0]   rdy;

    assign rdy[DEPTH] = out_ready;
    assign in_ready   = rdy[0];
    assign out_valid  = vld_reg[DEPTH-1];
    assign out_data   = pipe_reg[DEPTH-1].res;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_stage
        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        if (k == 0)
        begin : g_src0
            assign vld_next[k] = in_valid;
        end
        else
        begin : g_srcn
            assign vld_next[k] = vld_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (rdy[k])
                vld_reg[k] <= vld_next[k];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
                pipe_reg[k] <= pipe_next[k];
        end

        if (k == 0)
        begin : g_prep
            always_comb
            begin
                vec_t n;
                n      = '0;
                n.rv   = in_data;
                n.zero = (in_data.x == '0) && (in_data.y == '0);
                n.x    = XW'(in_data.x) <<< GUARD;
                n.y    = XW'(in_data.y) <<< GUARD;
                n.z    = '0;
                if (in_data.x < 0)
                begin
                    n.z = (in_data.y >= 0) ? PI_Q16 : -PI_Q16;
                    n.x = -n.x;
                    n.y = -n.y;
                end
                pipe_next[k] = n;
            end
        end
        else if (k < STAGES + 1)
        begin : g_cordic
            localparam int unsigned I = k - 1;
            always_comb
            begin
                vec_t n;
                logic signed [XW-1:0] xs;
                logic signed [XW-1:0] ys;
                n  = pipe_reg[k-1];
                xs = n.x >>> I;
                ys = n.y >>> I;
                if (n.y >= 0)
                begin
                    n.x = n.x + ys;
                    n.y = n.y - xs;
                    n.z = n.z + atan_q16(I);
                end
                else
                begin
                    n.x = n.x - ys;
                    n.y = n.y + xs;
                    n.z = n.z - atan_q16(I);
                end
                pipe_next[k] = n;
            end
        end
        else if (k == STAGES + 1)
        begin : g_mult
            always_comb
            begin
                vec_t n;
                n     = pipe_reg[k-1];
                n.phx = $signed(n.x[XW-1:LO_W]) * $signed({1'b0, INV_GAIN});
                n.plx = n.x[LO_W-1:0] * INV_GAIN;
                pipe_next[k] = n;
            end
        end
        else
        begin : g_final
            always_comb
            begin
                vec_t n;
                logic signed [DS_W-1:0] dm;
                logic signed [ZW-1:0]   zr;
                n  = pipe_reg[k-1];
                dm = descale(n.phx, n.plx);
                zr = (n.z + $signed(ZW'(4))) >>> 3;
                n.res.bad = n.rv.bad;
                n.res.x   = n.rv.x;
                n.res.y   = n.rv.y;
                if (dm < 0)
                    n.res.mag = '0;
                else if (dm > $signed(DS_W'(MAG_MAX)))
                    n.res.mag = MAG_MAX;
                else
                    n.res.mag = dm[CW-1:0];
                if (zr > ZW'(ANG_PI))
                    n.res.ang = ANG_PI;
                else if (zr < -ZW'(ANG_PI))
                    n.res.ang = -ANG_PI;
                else
                    n.res.ang = zr[AW-1:0];
                if (n.zero)
                begin
                    n.res.mag = '0;
                    n.res.ang = '0;
                end
                pipe_next[k] = n;
            end
        end
    end

endmodule

>>> design/rect_polar_vector_converter.sv
// Top level of the rectangular/polar vector converter.
// Depends on rpv_pkg, rpv_req_if, rpv_res_if, rpv_rotate and rpv_vector.
//
// Usage:
//   request carries kind (0 rectangular, 1 polar, else invalid), first_value
//   (x or signed magnitude, Q7.16) and second_value (y Q7.16 or angle Q10.13).
//   result carries x_out, y_out, magnitude (unsigned Q8.16), angle (Q2.13) and
//   invalid_form. Each request transaction gives exactly one result
//   transaction, in order.
//   NS = min(CORDIC_STAGES, 24) sets the length of the rotation and vectoring
//   CORDIC chains, one micro-rotation per stage.
//   Throughput: one transaction per cycle while result.ready stays high.
//   Reset empties the pipeline; no result is pending afterward.
//   When result.ready is low the last stage holds its transaction and each
//   stage keeps accepting until the bubbles in front of it are used up;
//   nothing is dropped or repeated.
module rect_polar_vector_converter import rpv_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input logic       clk,
    input logic       rst_n,
    rpv_req_if.sink   request,
    rpv_res_if.source result
);

    localparam int NS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

    req_t  req;
    rect_t rect;
    logic  rect_valid;
    logic  rect_ready;
    res_t  res;

    assign req.kind         = request.kind;
    assign req.first_value  = request.first_value;
    assign req.second_value = request.second_value;

    rpv_rotate #(
        .STAGES (NS)
    ) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .in_data   (req),
        .out_valid (rect_valid),
        .out_ready (rect_ready),
        .out_data  (rect)
    );

    rpv_vector #(
        .STAGES (NS)
    ) u_vector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rect_valid),
        .in_ready  (rect_ready),
        .in_data   (rect),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (res)
    );

    assign result.x_out        = res.x;
    assign result.y_out        = res.y;
    assign result.magnitude    = res.mag;
    assign result.angle        = res.ang;
    assign result.invalid_form = res.bad;

endmodule
